// File: rtl/pfrl_pkg.sv
// Package of the per-flag event rate limiter.
// Holds the input and result payload types and the fixed reset constants.
// Depends on nothing.
package pfrl_pkg;

  // One error report as it arrives on the input side.
  typedef struct packed {
    logic [2:0]  source;
    logic [31:0] flag_bits;
    logic [62:0] now_us;
  } item_t;

  // One reported flag as it leaves on the result side.
  typedef struct packed {
    logic [2:0] out_source;
    logic [4:0] flag_index;
    logic       last;
  } result_t;

  // Interval register value after reset, in microseconds.
  localparam logic [31:0] RESET_INTERVAL_US = 32'd1000000;

  // Timestamp that a never-written slot stands for: minus one second.
  localparam logic signed [64:0] RESET_TIME_US = -65'sd1000000;

endpackage

// File: rtl/per_flag_event_rate_limiter.sv
// Top level of the per-flag event rate limiter.
// Holds the scan sequencer, the shared time compare and the result register.
// Depends on pfrl_pkg and pfrl_ts_store.

// A report (source, flag word, current time) is taken when start is high
// and busy is low. The block then walks the flag bits one per cycle in
// ascending order, reading that slot's last-sent time from the timestamp
// store and comparing it through one shared 65-bit add and compare. A
// report keeps busy high through its scan, drain and finish states;
// the pace of the scan is set by the single read port of the timestamp
// store, which serves one slot per cycle. A report whose source is not
// below SOURCES is taken without any scan, yields nothing and
// leaves busy low. Each passing flag is presented on the result port for
// exactly one cycle with result_strobe high; the receiver cannot stall it,
// so it must take every result on that cycle. Because "last" can only be
// known once every later bit has been checked, a passing flag is held back
// until the next one passes or the scan ends, so results trail their check
// by one flag. The final result of a report carries last. Slots start at
// minus one second through written bits that reset clears at once, so the
// store needs no clearing pass and the block is ready right after reset.
// The interval register may be written at any time through the cfg
// channel, which is always ready; writes are meant to land while idle.
module per_flag_event_rate_limiter #(
  parameter int FLAGS   = 32,
  parameter int SOURCES = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pfrl_pkg::item_t  item,
  output logic             result_strobe,
  output pfrl_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  localparam int DEPTH = SOURCES * FLAGS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AWX   = AW + 4;
  localparam int IW    = (FLAGS > 1) ? $clog2(FLAGS) : 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state, state_next;
  logic [2:0]    src;
  logic [31:0]   bits;
  logic [62:0]   now;
  logic [IW-1:0] idx;
  logic [31:0]   interval;

  // Check stage: the slot whose stored time arrives this cycle.
  logic          chk_go;
  logic          chk_set;
  logic [IW-1:0] chk_idx;
  logic [AW-1:0] chk_addr;

  // Held-back passing flag, waiting to learn whether it is the last one.
  logic          pend_valid;
  logic [IW-1:0] pend_idx;

  logic [AWX-1:0] addr_full;
  logic [AW-1:0]  rd_addr;
  logic [62:0]    rd_time;
  logic           rd_written;
  logic           wr_en;

  logic signed [64:0] base_time;
  logic signed [64:0] threshold;
  logic               pass;
  logic               accept;
  logic               src_ok;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign src_ok    = {2'b00, item.source} < 5'(SOURCES);

  assign addr_full = AWX'(src) * AWX'(FLAGS) + AWX'(idx);
  assign rd_addr   = addr_full[AW-1:0];

  pfrl_ts_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_time   (rd_time),
    .rd_written(rd_written),
    .wr_en     (wr_en),
    .wr_addr   (chk_addr),
    .wr_time   (now)
  );

  // The shared compare: the flag passes when now > last_sent + interval.
  // An unwritten slot stands for minus one second.
  always_comb begin
    base_time = rd_written ? $signed({2'b00, rd_time}) : pfrl_pkg::RESET_TIME_US;
    threshold = base_time + $signed({33'd0, interval});
    pass      = $signed({2'b00, now}) > threshold;
  end

  assign wr_en = chk_go && chk_set && pass;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && src_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == IW'(FLAGS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      interval      <= pfrl_pkg::RESET_INTERVAL_US;
      chk_go        <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;
      chk_go        <= (state == ST_SCAN);

      if (cfg_valid && cfg_ready) begin
        interval <= cfg_data;
      end

      // A newly passing flag releases the one held back, which is not last.
      if (wr_en) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          result_strobe <= 1'b1;
        end
      end

      // With the scan over, the held-back flag is the report's final result.
      if (state == ST_FINISH) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          result_strobe <= 1'b1;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      src  <= item.source;
      bits <= item.flag_bits;
      now  <= item.now_us;
      idx  <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx + IW'(1);
    end

    chk_set  <= bits[idx];
    chk_idx  <= idx;
    chk_addr <= rd_addr;

    if (wr_en) begin
      pend_idx <= chk_idx;
      result.out_source <= src;
      result.flag_index <= 5'(pend_idx);
      result.last       <= 1'b0;
    end else if (state == ST_FINISH) begin
      result.out_source <= src;
      result.flag_index <= 5'(pend_idx);
      result.last       <= 1'b1;
    end
  end

  // The store is only written while a report is being scanned.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("timestamp write outside a scan");

  // A result only follows a cycle in which a report was in progress.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result without a report in progress");

  // The final result of a report is never followed at once by another.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |=> !result_strobe)
    else $error("result right after a last result");

  // A report with a source out of range leaves the block idle.
  a_bad_source: assert property (@(posedge clk) disable iff (rst)
    (accept && !src_ok) |=> !busy)
    else $error("out-of-range source started a scan");

  // Nothing is held back once the block is idle.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!pend_valid && !chk_go))
    else $error("pending flag left over at idle");

endmodule

// File: rtl/pfrl_ts_store.sv
// Timestamp store of the per-flag event rate limiter.
// One 63-bit time per (source, flag) slot, with a written bit per slot.
// Depends on nothing; the top level interprets unwritten slots.
module pfrl_ts_store #(
  parameter int DEPTH = 192,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [62:0]   rd_time,
  output logic          rd_written,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [62:0]   wr_time
);

  logic [62:0]      mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_time;
    end
    rd_time <= mem[rd_addr];
  end

  // Written bits clear at reset, so an unwritten slot reads as the reset time.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the per-flag event rate limiter.
// Holds its own prediction of the per-slot timestamps and the interval register.
// Depends on pfrl_pkg and per_flag_event_rate_limiter.
module testbench;

  localparam int FLAGS = 32;
  localparam int SOURCES = 6;

  // A report keeps the block busy through its scan, drain and finish states.
  // After the last expected flag has arrived, the scan may still be walking
  // bits that fail. This margin covers that tail.
  localparam int SCAN_TAIL = FLAGS + 4;

  // The run ends with a failure once this many cycles pass with no transfer.
  // The slowest correct wait is one scan plus a sender gap plus the idle tail.
  localparam int STALL_LIMIT = 4000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  pfrl_pkg::item_t   report_item = '0;
  logic              result_strobe;
  pfrl_pkg::result_t flag_result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data = '0;

  per_flag_event_rate_limiter #(
    .FLAGS  (FLAGS),
    .SOURCES(SOURCES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (report_item),
    .result_strobe(result_strobe),
    .result       (flag_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted state: the last-sent time of every (source, flag) slot, held as a
  // 65-bit signed value so that minus one second and any 63-bit time fit, and
  // the interval register as the block should hold it.
  logic signed [64:0] sent_time_us [SOURCES*FLAGS];
  logic [31:0]        interval_us;

  // Flags that the block owes us, oldest first.
  pfrl_pkg::result_t expected_flags [$];

  int errors = 0;
  int reports_sent = 0;
  int results_seen = 0;
  int interval_writes = 0;
  int idle_pct = 12;
  int stall_cycles = 0;

  // Running time base of the random traffic.
  logic [62:0] clock_us;

  // Every mismatch goes through here: one line, one count.
  task automatic flag_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Works out which set flags of one report pass the interval check, updates
  // their timestamps and queues the flags they should produce. The final one
  // carries last, which is why the passing bits are collected first.
  function automatic void predict_report(input pfrl_pkg::item_t rpt);
    logic [FLAGS-1:0]   pass_mask;
    logic signed [64:0] elapsed;
    int                 slot;
    pass_mask = '0;
    if (rpt.source >= SOURCES) return;
    for (int i = 0; i < FLAGS; i++) begin
      if (rpt.flag_bits[i]) begin
        slot = int'(rpt.source) * FLAGS + i;
        // Exact difference; a time that went backwards gives a negative value
        // and can never beat the interval.
        elapsed = $signed({2'b00, rpt.now_us}) - sent_time_us[slot];
        if (elapsed > $signed({33'd0, interval_us})) begin
          sent_time_us[slot] = $signed({2'b00, rpt.now_us});
          pass_mask[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < FLAGS; i++) begin
      if (pass_mask[i]) begin
        expected_flags.push_back('{out_source: rpt.source,
                                   flag_index: 5'(i),
                                   last: ((pass_mask >> (i + 1)) == '0)});
      end
    end
  endfunction

  // Hands one report to the block. A random gap, if any, is taken by lowering
  // start first; with no gap start simply stays high and the next report
  // follows straight behind the previous transfer.
  task automatic send_report(input pfrl_pkg::item_t rpt);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    report_item <= rpt;
    // The transfer happens at the first edge that sees busy low.
    do @(posedge clk); while (busy);
    predict_report(rpt);
    reports_sent++;
  endtask

  // Waits until every owed flag has come and the scan has had time to finish
  // its remaining failing bits, so the block is idle afterwards.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (SCAN_TAIL) @(posedge clk);
  endtask

  // Writes the interval register; only called while the block is idle.
  task automatic write_interval(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    interval_us = value;
    interval_writes++;
  endtask

  function automatic pfrl_pkg::item_t make_report(input logic [2:0] src,
                                                  input logic [31:0] bits,
                                                  input logic [62:0] now);
    pfrl_pkg::item_t rpt;
    rpt.source    = src;
    rpt.flag_bits = bits;
    rpt.now_us    = now;
    return rpt;
  endfunction

  // One random report. Time mostly moves forward by amounts near the interval,
  // so that flags pass and fail in roughly equal measure; now and then it goes
  // backwards or jumps to an arbitrary 63-bit value.
  function automatic pfrl_pkg::item_t random_report();
    logic [63:0]       wide;
    longint unsigned   step;
    logic [31:0]       bits;
    logic [2:0]        src;
    int                kind;
    wide = {$urandom(), $urandom()};
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      // Right at the boundary: one below, equal to, or one above the interval.
      step = longint'(interval_us) + $urandom_range(0, 2);
      if (step > 0) step--;
      clock_us = 63'(clock_us + step);
    end else if (kind <= 7) begin
      step = wide % (2 * longint'(interval_us) + 3);
      clock_us = 63'(clock_us + step);
    end else if (kind == 8) begin
      step = wide % (longint'(interval_us) + 1);
      clock_us = 63'(clock_us - step);
    end else begin
      clock_us = wide[62:0];
    end

    case ($urandom_range(0, 4))
      0:       bits = 32'd1 << $urandom_range(0, 31);
      1:       bits = $urandom() & $urandom() & $urandom();
      2:       bits = $urandom() | $urandom();
      3:       bits = '1;
      default: bits = $urandom();
    endcase

    // Mostly valid sources; a few out of range ones that must stay silent.
    if ($urandom_range(0, 99) < 10) src = 3'(6 + $urandom_range(0, 1));
    else src = 3'($urandom_range(0, SOURCES - 1));
    return make_report(src, bits, clock_us);
  endfunction

  // Directed reports with the interval as it comes out of reset. Slots start
  // at minus one second, so time zero lands exactly on the interval and fails.
  task automatic test_reset_interval();
    send_report(make_report(3'd0, 32'hFFFF_FFFF, 63'd0));
    // One microsecond later every flag of source 0 passes: the largest burst.
    send_report(make_report(3'd0, 32'hFFFF_FFFF, 63'd1));
    // Out of range sources give nothing and leave no trace.
    send_report(make_report(3'd6, 32'hFFFF_FFFF, 63'd5));
    send_report(make_report(3'd7, 32'hFFFF_FFFF, 63'd5));
    // An empty flag word gives nothing.
    send_report(make_report(3'd5, 32'h0000_0000, 63'd5));
    // The lowest and the highest bit together.
    send_report(make_report(3'd3, 32'h8000_0001, 63'd1000000));
    // Exactly one interval after the burst: equal is not enough.
    send_report(make_report(3'd0, 32'hFFFF_FFFF, 63'd1000001));
    send_report(make_report(3'd0, 32'hFFFF_FFFF, 63'd1000002));
    // Time going backwards never reports.
    send_report(make_report(3'd0, 32'h0000_0001, 63'd7));
    // The largest time there is, on the last source.
    send_report(make_report(3'd5, 32'hFFFF_FFFF, {63{1'b1}}));
    send_report(make_report(3'd4, 32'h8000_0000, {63{1'b1}}));
    drain_results();
  endtask

  // The interval at zero and at its largest value.
  task automatic test_interval_extremes();
    write_interval(32'd0);
    send_report(make_report(3'd1, 32'hA5A5_A5A5, 63'd100));
    // Zero elapsed time does not beat a zero interval; one microsecond does.
    send_report(make_report(3'd1, 32'hA5A5_A5A5, 63'd100));
    send_report(make_report(3'd1, 32'hA5A5_A5A5, 63'd101));
    drain_results();
    write_interval(32'hFFFF_FFFF);
    // The bits sent at 101 sit exactly one interval back; the others pass.
    send_report(make_report(3'd1, 32'hFFFF_FFFF, 63'd101 + 63'hFFFF_FFFF));
    send_report(make_report(3'd1, 32'hFFFF_FFFF, 63'd102 + 63'hFFFF_FFFF));
    send_report(make_report(3'd2, 32'h0001_0000, 63'd0));
    drain_results();
  endtask

  // A phase of random traffic at one interval setting.
  task automatic test_random_traffic(input logic [31:0] interval, input int count,
                                     input int idle);
    write_interval(interval);
    idle_pct = idle;
    for (int n = 0; n < count; n++) send_report(random_report());
    drain_results();
  endtask

  // Every flag that comes out is taken on its strobe cycle and checked against
  // the oldest owed one.
  pfrl_pkg::result_t want;
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_flags.size() == 0) begin
        flag_mismatch($sformatf("unexpected flag: source %0d bit %0d last %0b",
                                flag_result.out_source, flag_result.flag_index,
                                flag_result.last));
      end else begin
        want = expected_flags.pop_front();
        results_seen++;
        if (flag_result.out_source !== want.out_source)
          flag_mismatch($sformatf("out_source %0d, expected %0d",
                                  flag_result.out_source, want.out_source));
        if (flag_result.flag_index !== want.flag_index)
          flag_mismatch($sformatf("flag_index %0d, expected %0d (source %0d)",
                                  flag_result.flag_index, want.flag_index,
                                  want.out_source));
        if (flag_result.last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b (source %0d bit %0d)",
                                  flag_result.last, want.last, want.out_source,
                                  want.flag_index));
      end
    end
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d flags still owed",
                 STALL_LIMIT, expected_flags.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int s = 0; s < SOURCES * FLAGS; s++) sent_time_us[s] = pfrl_pkg::RESET_TIME_US;
    interval_us = pfrl_pkg::RESET_INTERVAL_US;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_interval();
    test_interval_extremes();

    clock_us = 63'd2000000;
    test_random_traffic(32'($urandom_range(0, 3000)), 60, 12);
    test_random_traffic($urandom(), 60, 12);
    // A long stretch with reports back to back.
    test_random_traffic(32'd1, 60, 0);
    test_random_traffic(pfrl_pkg::RESET_INTERVAL_US, 30, 12);
    test_random_traffic(32'($urandom_range(0, 50000)), 30, 12);

    if (expected_flags.size() != 0)
      flag_mismatch($sformatf("%0d flags never arrived", expected_flags.size()));

    $display("Covered %0d reports, %0d flags checked, %0d interval settings,",
             reports_sent, results_seen, interval_writes);
    $display("including reset slots, out of range sources and time going backwards.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
